FILE: hw/rtl/sfwrm_pkg.sv
// Shared types, constants and BCD helpers for the window range monitor.
package sfwrm_pkg;

   localparam int DISP_W = 20;
   localparam int SEC_W = 16;
   localparam int BYTE_W = 8;
   localparam int HELD_BYTES = 3;

   localparam int WINDOW_SECONDS_DEF = 10;
   localparam int FRAME_BYTES_DEF = 4;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;
   localparam logic [SEC_W-1:0] SECONDS_MAX = 16'hFFFF;
   localparam logic [DISP_W-1:0] THRESHOLD_RESET = 20'd100;
   localparam logic [DISP_W-1:0] SCALE_HI = 20'd10000;
   localparam logic [DISP_W-1:0] SCALE_MID = 20'd100;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_WINDOW = 1'b1;

   typedef struct packed {
      logic              done;
      logic              bad;
      logic [DISP_W-1:0] disp;
   } sample_type;

   typedef struct packed {
      logic              started;
      logic [SEC_W-1:0]  seconds;
      logic [DISP_W-1:0] range;
      logic              ready;
      logic              stable;
      logic              valid;
   } window_type;

   function automatic logic bcd_ok(input logic [BYTE_W-1:0] b);
      return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
   endfunction

   function automatic logic [6:0] bcd_val(input logic [BYTE_W-1:0] b);
      return 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
   endfunction

endpackage

FILE: hw/rtl/sfwrm_frame_decoder.sv
// Frame assembly and BCD decode of the serial byte stream.
module sfwrm_frame_decoder #(
   parameter int FRAME_BYTES = sfwrm_pkg::FRAME_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [sfwrm_pkg::BYTE_W-1:0]        data_byte,
   output sfwrm_pkg::sample_type               sample
);

   localparam logic [2:0] LAST_COUNT = 3'(FRAME_BYTES - 1);

   logic                         frame_open_ff, frame_open_in;
   logic [2:0]                   frame_count_ff, frame_count_in;
   logic [sfwrm_pkg::BYTE_W-1:0] frame_bytes_ff [sfwrm_pkg::HELD_BYTES];
   logic [sfwrm_pkg::BYTE_W-1:0] merged [sfwrm_pkg::HELD_BYTES];
   logic                         last;

   assign last = frame_open_ff && (frame_count_ff == LAST_COUNT);

   // the last byte may also be a digit byte when the frame is short
   always_comb begin
      for (int i = 0; i < sfwrm_pkg::HELD_BYTES; i++) begin
         merged[i] = (frame_open_ff && frame_count_ff == 3'(i)) ? data_byte : frame_bytes_ff[i];
      end
   end

   always_comb begin
      sample.done = step && last;
      sample.bad = !(sfwrm_pkg::bcd_ok(merged[0]) && sfwrm_pkg::bcd_ok(merged[1])
                     && sfwrm_pkg::bcd_ok(merged[2]));
      if (sample.bad) begin
         sample.disp = '0;
      end else begin
         sample.disp = sfwrm_pkg::DISP_W'(sfwrm_pkg::bcd_val(merged[2])) * sfwrm_pkg::SCALE_HI
                     + sfwrm_pkg::DISP_W'(sfwrm_pkg::bcd_val(merged[1])) * sfwrm_pkg::SCALE_MID
                     + sfwrm_pkg::DISP_W'(sfwrm_pkg::bcd_val(merged[0]));
      end
   end

   always_comb begin
      frame_open_in = frame_open_ff;
      frame_count_in = frame_count_ff;
      if (step) begin
         if (!frame_open_ff) begin
            if (data_byte == sfwrm_pkg::START_BYTE) begin
               frame_open_in = 1'b1;
               frame_count_in = '0;
            end
         end else if (last) begin
            frame_open_in = 1'b0;
            frame_count_in = '0;
         end else begin
            frame_count_in = frame_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         frame_count_ff <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         frame_count_ff <= frame_count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sfwrm_pkg::HELD_BYTES; i++) begin
         if (step && frame_open_ff && frame_count_ff == 3'(i)) begin
            frame_bytes_ff[i] <= data_byte;
         end
      end
   end

endmodule

FILE: hw/rtl/sfwrm_window.sv
// Second counter and the bank of overlapping min/max buckets.
module sfwrm_window #(
   parameter int WINDOW_SECONDS = sfwrm_pkg::WINDOW_SECONDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           store,
   input  logic [sfwrm_pkg::DISP_W-1:0]   value,
   input  logic                           tick,
   input  logic [sfwrm_pkg::DISP_W-1:0]   threshold,
   output sfwrm_pkg::window_type          report
);

   localparam int IDX_W = $clog2(WINDOW_SECONDS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SECONDS - 1);
   localparam logic [sfwrm_pkg::SEC_W-1:0] SEC_READY = sfwrm_pkg::SEC_W'(WINDOW_SECONDS - 1);
   localparam logic [sfwrm_pkg::SEC_W-1:0] SEC_VALID = sfwrm_pkg::SEC_W'(WINDOW_SECONDS);

   logic                          started_ff;
   logic [sfwrm_pkg::SEC_W-1:0]   seconds_ff, seconds_in;
   logic [IDX_W-1:0]              head_ff, head_in, head_inc, rep_idx;
   logic [sfwrm_pkg::DISP_W-1:0]  bucket_max_ff [WINDOW_SECONDS];
   logic [sfwrm_pkg::DISP_W-1:0]  bucket_min_ff [WINDOW_SECONDS];
   logic [WINDOW_SECONDS-1:0]     filled_ff;
   logic [WINDOW_SECONDS-1:0]     hit;
   logic                          ready, valid;
   logic [sfwrm_pkg::DISP_W-1:0]  range;

   // head_ff tracks seconds mod window; it freezes with the saturated count
   assign head_inc = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
   assign seconds_in = (seconds_ff != sfwrm_pkg::SECONDS_MAX) ? seconds_ff + 16'd1 : seconds_ff;
   assign head_in = (seconds_ff != sfwrm_pkg::SECONDS_MAX) ? head_inc : head_ff;
   // expiring bucket is (seconds_in + 1) mod window
   assign rep_idx = (head_in == IDX_LAST) ? '0 : head_in + IDX_W'(1);

   assign ready = seconds_in >= SEC_READY;
   assign valid = seconds_in >= SEC_VALID;
   assign range = (ready && filled_ff[rep_idx]) ? bucket_max_ff[rep_idx] - bucket_min_ff[rep_idx]
                                                : '0;

   always_comb begin
      report.started = started_ff;
      report.seconds = tick ? seconds_in : seconds_ff;
      report.range = range;
      report.ready = ready;
      report.valid = valid;
      report.stable = valid && (range < threshold);
   end

   always_comb begin
      for (int b = 0; b < WINDOW_SECONDS; b++) begin
         hit[b] = (seconds_ff >= SEC_READY) || (sfwrm_pkg::SEC_W'(b) <= seconds_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         seconds_ff <= '0;
         head_ff <= '0;
         filled_ff <= '0;
      end else begin
         if (store) begin
            started_ff <= 1'b1;
            filled_ff <= filled_ff | hit;
         end
         if (tick && started_ff) begin
            seconds_ff <= seconds_in;
            head_ff <= head_in;
            if (valid) begin
               filled_ff[head_in] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < WINDOW_SECONDS; b++) begin
         if (store && hit[b]) begin
            if (!filled_ff[b] || value > bucket_max_ff[b]) begin
               bucket_max_ff[b] <= value;
            end
            if (!filled_ff[b] || value < bucket_min_ff[b]) begin
               bucket_min_ff[b] <= value;
            end
         end
      end
   end

endmodule

FILE: hw/rtl/sensor_frame_window_range_monitor_unit.sv
// Top level: request and response registers around frame decode and window bank.
// Path: a taken request is held in the input register and moves into the response
// register once that register is empty or its response is being accepted.
// Throughput: one request per cycle unless the response side stalls; bytes that
// close no frame and ticks before the first good sample produce no response.
// Reset: synchronous active-high; clears framing, seconds, bucket fill flags and
// sets the threshold to 100. Bucket contents are not cleared.
module sensor_frame_window_range_monitor_unit #(
   parameter int WINDOW_SECONDS = sfwrm_pkg::WINDOW_SECONDS_DEF,
   parameter int FRAME_BYTES = sfwrm_pkg::FRAME_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [sfwrm_pkg::DISP_W-1:0]   csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [sfwrm_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_kind,
   output logic [sfwrm_pkg::DISP_W-1:0]   rsp_displacement,
   output logic                           rsp_bad_digits,
   output logic [sfwrm_pkg::SEC_W-1:0]    rsp_elapsed_seconds,
   output logic [sfwrm_pkg::DISP_W-1:0]   rsp_window_range,
   output logic                           rsp_range_ready,
   output logic                           rsp_stable,
   output logic                           rsp_stable_valid
);

   logic                          in_valid_ff;
   logic                          cmd_ff;
   logic [sfwrm_pkg::BYTE_W-1:0]  byte_ff;
   logic [sfwrm_pkg::DISP_W-1:0]  threshold_ff;
   logic                          out_valid_ff;
   logic                          kind_ff, bad_ff, ready_ff, stable_ff, valid_ff;
   logic [sfwrm_pkg::DISP_W-1:0]  disp_ff, range_ff;
   logic [sfwrm_pkg::SEC_W-1:0]   seconds_ff;

   logic                          advance, has_result, is_tick;
   sfwrm_pkg::sample_type         sample;
   sfwrm_pkg::window_type         win;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign is_tick = cmd_ff == sfwrm_pkg::CMD_TICK;
   assign has_result = is_tick ? win.started : sample.done;

   sfwrm_frame_decoder #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_decoder (
      .clock(clock),
      .reset(reset),
      .step(advance && !is_tick),
      .data_byte(byte_ff),
      .sample(sample)
   );

   sfwrm_window #(
      .WINDOW_SECONDS(WINDOW_SECONDS)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .store(sample.done && !sample.bad),
      .value(sample.disp),
      .tick(advance && is_tick),
      .threshold(threshold_ff),
      .report(win)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sfwrm_pkg::THRESHOLD_RESET;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= has_result;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_command;
         byte_ff <= req_data_byte;
      end
      if (advance && has_result) begin
         seconds_ff <= win.seconds;
         if (is_tick) begin
            kind_ff <= sfwrm_pkg::KIND_WINDOW;
            disp_ff <= '0;
            bad_ff <= 1'b0;
            range_ff <= win.range;
            ready_ff <= win.ready;
            stable_ff <= win.stable;
            valid_ff <= win.valid;
         end else begin
            kind_ff <= sfwrm_pkg::KIND_SAMPLE;
            disp_ff <= sample.disp;
            bad_ff <= sample.bad;
            range_ff <= '0;
            ready_ff <= 1'b0;
            stable_ff <= 1'b0;
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_displacement = disp_ff;
   assign rsp_bad_digits = bad_ff;
   assign rsp_elapsed_seconds = seconds_ff;
   assign rsp_window_range = range_ff;
   assign rsp_range_ready = ready_ff;
   assign rsp_stable = stable_ff;
   assign rsp_stable_valid = valid_ff;

`ifndef SYNTH
   a_sample_no_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sfwrm_pkg::KIND_SAMPLE |->
         rsp_window_range == '0 && !rsp_range_ready && !rsp_stable_valid)
      else $error("sample response carries window fields");
   a_stable_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stable |-> rsp_stable_valid && rsp_range_ready)
      else $error("stable flagged before window is complete");
   a_bad_zero_disp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_digits |-> rsp_displacement == '0 && !rsp_kind)
      else $error("bad frame reported with a displacement");
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && $stable(cmd_ff))
      else $error("pending request dropped while response stalled");
`endif

endmodule
